// ----- src/ppc_pkg.sv -----
// Shared constants and types for the page pattern hit counter.
package ppc_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int PAGE_BYTES_DEF  = 16384;

  localparam int BYTE_W     = 8;
  localparam int PAT_BYTES  = 16;
  localparam int LEN_W      = 5;
  localparam int COUNT_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [COUNT_W-1:0] HIT_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_reg_t;

endpackage

// ----- src/page_pattern_hit_counter_unit.sv -----
// Page pattern hit counter: streams page bytes and reports non-overlapping pattern hits.
//
// Each request carries one page byte: the byte is shifted into a window of the newest
// MAX_PATTERN bytes and compared against the configured pattern in one registered pass,
// so a new byte is taken every cycle unless input stalls. A hit counts only when it
// shares no byte with the previous hit, leftmost first. The byte flagged last ends the
// page: the page's hit count (saturating at 32767) goes to a result register and the
// page state clears. Bytes after the first PAGE_BYTES of a page are ignored, though a
// last flag on them still ends the page. Input stalls only while a finished count waits
// in the result register and out_ready is low. Pattern registers are written through the
// cfg port; the user must do so only while no page is in flight: the block won't check.
module page_pattern_hit_counter_unit #(
  parameter int MAX_PATTERN = ppc_pkg::MAX_PATTERN_DEF,
  parameter int PAGE_BYTES  = ppc_pkg::PAGE_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ppc_pkg::BYTE_W-1:0]       in_page_byte,
  input  logic                             in_last_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ppc_pkg::COUNT_W-1:0]      out_hit_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ppc_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int PW = $clog2(PAGE_BYTES + 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [LEN_W-1:0]      pat_len_r;

  // page state
  logic [BYTE_W-1:0]  win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]  win_nxt [MAX_PATTERN];
  logic [LW-1:0]      seen_r, seen_nxt;
  logic [LW-1:0]      since_r, since_nxt;
  logic [COUNT_W-1:0] hits_r, hits_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;

  logic [BYTE_W-1:0]      pat     [MAX_PATTERN];
  logic [2*CFG_DATA_W-1:0] pat_bits;
  logic [LW-1:0]          len_eff;
  logic [LW-1:0]          seen_inc, since_inc;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic                   match, hit, active, in_acc, cfg_acc;

  assign in_acc    = in_valid & in_ready;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_ready  = ~out_valid_r | out_ready;
  assign cfg_ready = 1'b1;
  assign active    = pos_r < PW'(PAGE_BYTES);

  assign out_valid     = out_valid_r;
  assign out_hit_count = out_count_r;

  // Pattern bytes past the register pair read as zero.
  assign pat_bits = {pat_high_r, pat_low_r};
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
    if (g < PAT_BYTES) begin : g_reg
      assign pat[g] = pat_bits[BYTE_W*g +: BYTE_W];
    end else begin : g_zero
      assign pat[g] = '0;
    end
  end

  // Clamp the length into 1..MAX_PATTERN.
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(pat_len_r) > 32'(MAX_PATTERN)) begin
      len_eff = LW'(MAX_PATTERN);
    end else begin
      len_eff = LW'(pat_len_r);
    end
  end

  // Shift the new byte in, newest at index 0.
  always_comb begin
    win_nxt[0] = in_page_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  // Window slot j holds pattern byte len-1-j; slots at or past len always pass.
  always_comb begin
    logic [BYTE_W-1:0] sel;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      sel = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (k == int'(len_eff) - 1 - j) begin
          sel = pat[k];
        end
      end
      pos_ok[j] = (j >= int'(len_eff)) || (win_nxt[j] == sel);
    end
  end

  assign match     = &pos_ok;
  assign seen_inc  = (seen_r  < LW'(MAX_PATTERN)) ? seen_r  + LW'(1) : seen_r;
  assign since_inc = (since_r < LW'(MAX_PATTERN)) ? since_r + LW'(1) : since_r;
  assign hit       = active && match && (seen_inc >= len_eff) && (since_inc >= len_eff);

  always_comb begin
    seen_nxt  = seen_r;
    since_nxt = since_r;
    hits_nxt  = hits_r;
    pos_nxt   = pos_r;
    if (active) begin
      seen_nxt  = seen_inc;
      since_nxt = hit ? '0 : since_inc;
      pos_nxt   = pos_r + PW'(1);
      if (hit && hits_r != HIT_MAX) begin
        hits_nxt = hits_r + COUNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= LEN_RESET;
    end else if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAT_LOW:  pat_low_r  <= cfg_data;
        CFG_PAT_HIGH: pat_high_r <= cfg_data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      since_r     <= LW'(MAX_PATTERN);
      hits_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        if (in_last_byte) begin
          seen_r  <= '0;
          since_r <= LW'(MAX_PATTERN);
          hits_r  <= '0;
          pos_r   <= '0;
        end else begin
          seen_r  <= seen_nxt;
          since_r <= since_nxt;
          hits_r  <= hits_nxt;
          pos_r   <= pos_nxt;
        end
      end
    end
  end

  // Stale window bytes are compared but cannot make a hit: seen_inc gates every slot in use.
  always_ff @(posedge clk) begin
    if (in_acc && active) begin
      win_r <= win_nxt;
    end
    if (in_acc && in_last_byte) begin
      out_count_r <= hits_nxt;
    end
  end

  a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> out_valid_r && out_count_r == $past(hits_nxt))
    else $error("page end did not load the hit count");

  a_last_clears_page: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> seen_r == '0 && hits_r == '0 && pos_r == '0 &&
      since_r == LW'(MAX_PATTERN))
    else $error("page state not cleared at page end");

  a_hit_needs_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> seen_inc >= len_eff && since_inc >= len_eff && active)
    else $error("hit counted without a full, unblocked window");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last_byte |=> hits_r >= $past(hits_r))
    else $error("hit count dropped within a page");

  a_counters_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LW'(MAX_PATTERN) && since_r <= LW'(MAX_PATTERN) && pos_r <= PW'(PAGE_BYTES))
    else $error("page counter beyond its limit");

endmodule

// ----- dv/tb_page_pattern_hit_counter_unit.sv -----
// Self-checking testbench for the page pattern hit counter unit.
module tb_page_pattern_hit_counter_unit;
  import ppc_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 1650;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // page styles
  localparam int PAGE_WELL  = 0;
  localparam int PAGE_NOISE = 1;

  // pattern shapes
  localparam int PAT_RANDOM     = 0;
  localparam int PAT_UNIFORM    = 1;
  localparam int PAT_ALTERNATE  = 2;
  localparam int PAT_TWO_SYMBOL = 3;
  localparam int PAT_ONES       = 4;
  localparam int PAT_ZEROS      = 5;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } page_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_page_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_W-1:0]    out_hit_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  page_pattern_hit_counter_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_page_byte (in_page_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_hit_count(out_hit_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  page_req_t          page_req_q[$];
  logic [COUNT_W-1:0] hit_expect_q[$];
  int                 cycle_count = 0;
  int                 mismatches = 0;
  int                 pushed_count = 0;
  bit                 in_taken = 1'b0;
  int                 send_gap = 0;
  bit                 send_calm = 1'b0;
  int                 recv_stall = 0;
  bit                 recv_calm = 1'b0;
  page_req_t          cur_req;

  // predicted block state
  logic [CFG_DATA_W-1:0] pat_lo = '0;
  logic [CFG_DATA_W-1:0] pat_hi = '0;
  logic [LEN_W-1:0]      pat_len = LEN_RESET;
  logic [BYTE_W-1:0]     win_bytes [MAX_PATTERN_DEF];
  int                    seen_cnt = 0;
  int                    since_hit = MAX_PATTERN_DEF;
  int                    page_hits = 0;
  int                    page_pos = 0;

  // stimulus view of the loaded pattern
  logic [BYTE_W-1:0] gen_pat [PAT_BYTES];
  int                gen_len = 1;

  initial begin
    for (int k = 0; k < MAX_PATTERN_DEF; k++) win_bytes[k] = '0;
  end

  function automatic int eff_length(input logic [LEN_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] pattern_at(input int k);
    if (k < 8) return pat_lo[8*k +: 8];
    return pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic clear_page_state();
    for (int k = 0; k < MAX_PATTERN_DEF; k++) win_bytes[k] = '0;
    seen_cnt = 0;
    since_hit = MAX_PATTERN_DEF;
    page_hits = 0;
    page_pos = 0;
  endtask

  task automatic count_byte(input logic [BYTE_W-1:0] b, input logic last);
    int  n;
    bit  match;
    if (page_pos < PAGE_BYTES_DEF) begin
      page_pos++;
      n = eff_length(pat_len);
      for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = b;
      if (seen_cnt < MAX_PATTERN_DEF) seen_cnt++;
      if (since_hit < MAX_PATTERN_DEF) since_hit++;
      if (seen_cnt >= n && since_hit >= n) begin
        match = 1'b1;
        for (int k = 0; k < n; k++) begin
          if (win_bytes[n-1-k] != pattern_at(k)) match = 1'b0;
        end
        if (match) begin
          if (page_hits < int'(HIT_MAX)) page_hits++;
          since_hit = 0;
        end
      end
    end
    if (last) begin
      hit_expect_q.push_back(COUNT_W'(page_hits));
      clear_page_state();
    end
  endtask

  // monitor: check results, track register writes, predict accepted requests
  always @(posedge clk) begin
    cycle_count++;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (hit_expect_q.size() == 0) begin
          $display("%0t: hit_count expected none, actual %0d", $time, out_hit_count);
          mismatches++;
        end else begin
          if (out_hit_count !== hit_expect_q[0]) begin
            $display("%0t: hit_count expected %0d, actual %0d",
                     $time, hit_expect_q[0], out_hit_count);
            mismatches++;
          end
          void'(hit_expect_q.pop_front());
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAT_LOW:  pat_lo = cfg_data;
          CFG_PAT_HIGH: pat_hi = cfg_data;
          CFG_PAT_LEN:  pat_len = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        count_byte(in_page_byte, in_last_byte);
      end
    end
  end

  // driver: one request per handshake, random gaps in between
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (page_req_q.size() > 0) begin
        cur_req = page_req_q.pop_front();
        in_valid <= 1'b1;
        in_page_byte <= cur_req.data;
        in_last_byte <= cur_req.last;
        send_gap = pick_gap(send_calm);
        if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_stall = pick_gap(recv_calm);
      if ($urandom_range(0, 299) == 0) recv_calm = !recv_calm;
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    page_req_t r;
    r.data = b;
    r.last = last;
    page_req_q.push_back(r);
    pushed_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until the block is idle, then let it settle
  task automatic wait_idle(input int settle);
    while (page_req_q.size() != 0 || in_valid || hit_expect_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_pattern(input int shape, input logic [CFG_DATA_W-1:0] len_word);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [BYTE_W-1:0]     a;
    logic [BYTE_W-1:0]     b;
    a = BYTE_W'($urandom);
    b = BYTE_W'($urandom);
    for (int k = 0; k < PAT_BYTES; k++) begin
      case (shape)
        PAT_UNIFORM:    gen_pat[k] = a;
        PAT_ALTERNATE:  gen_pat[k] = (k % 2) ? b : a;
        PAT_TWO_SYMBOL: gen_pat[k] = $urandom_range(0, 1) ? b : a;
        PAT_ONES:       gen_pat[k] = '1;
        PAT_ZEROS:      gen_pat[k] = '0;
        default:        gen_pat[k] = BYTE_W'($urandom);
      endcase
      if (k < 8) lo[8*k +: 8] = gen_pat[k];
      else hi[8*(k-8) +: 8] = gen_pat[k];
    end
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
    write_reg(CFG_PAT_LEN, len_word);
    gen_len = eff_length(len_word[LEN_W-1:0]);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_len_word(input int phase);
    logic [CFG_DATA_W-1:0] w;
    int                    v;
    int                    r;
    r = $urandom_range(0, 9);
    case (phase)
      0: v = 16;
      1: v = 1;
      2: v = 0;
      3: v = 31;
      default: begin
        if (r == 0) v = 0;
        else if (r == 1) v = 1;
        else if (r == 2) v = 16;
        else if (r == 3) v = $urandom_range(17, 31);
        else v = $urandom_range(2, 15);
      end
    endcase
    w = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    w[LEN_W-1:0] = LEN_W'(v);
    return w;
  endfunction

  // mix full copies, broken prefixes and stray bytes of the pattern
  task automatic queue_page(input int len, input int style);
    int i;
    int pick;
    int run;
    i = 0;
    while (i < len) begin
      pick = $urandom_range(0, 99);
      if (style == PAGE_NOISE || pick < 15) begin
        push_byte(BYTE_W'($urandom), i == len - 1);
        i++;
      end else begin
        if (pick < 55) run = gen_len;
        else if (pick < 75) run = $urandom_range(1, gen_len);
        else run = 1;
        for (int k = 0; k < run && i < len; k++) begin
          if (run == 1) push_byte(gen_pat[$urandom_range(0, gen_len - 1)], i == len - 1);
          else push_byte(gen_pat[k], i == len - 1);
          i++;
        end
      end
    end
  endtask

  initial begin
    int phase;
    int phase_start;
    int plen;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset pattern is a single zero byte
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle(4);

    // zero length behaves as one; unused index is dropped
    write_reg(CFG_UNUSED_IDX, '1);
    write_reg(CFG_PAT_LOW, 64'h0000_0000_0000_00AB);
    write_reg(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    push_byte(8'hAB, 1'b0);
    push_byte(8'hAB, 1'b0);
    push_byte(8'hAB, 1'b1);
    wait_idle(4);

    // self-overlapping pattern: take leftmost, skip overlaps
    write_reg(CFG_PAT_LOW, 64'h0000_0000_0000_4141);
    write_reg(CFG_PAT_LEN, 64'd2);
    for (int k = 0; k < 5; k++) push_byte(8'h41, k == 4);
    wait_idle(4);

    // over-long length clamps to the full window
    write_reg(CFG_PAT_LOW, '1);
    write_reg(CFG_PAT_HIGH, '1);
    write_reg(CFG_PAT_LEN, 64'd31);
    for (int k = 0; k < 16; k++) push_byte(8'hFF, k == 15);
    wait_idle(4);

    pushed_count = 0;
    phase = 0;
    while (pushed_count < RANDOM_ITEMS) begin
      case (phase)
        0: load_pattern(PAT_ONES, pick_len_word(phase));
        1: load_pattern(PAT_ZEROS, pick_len_word(phase));
        default: load_pattern($urandom_range(PAT_RANDOM, PAT_ZEROS), pick_len_word(phase));
      endcase
      phase_start = pushed_count;
      while (pushed_count - phase_start < 150) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        queue_page(plen, ($urandom_range(0, 99) < 15) ? PAGE_NOISE : PAGE_WELL);
      end
      wait_idle(4);
      phase++;
    end

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
